/* sv/tet_pkg.sv */
// touch event tracker package: shared types, codes, widths and reset values
// no dependencies; used by every module of the block

package tet_pkg;

  localparam int unsigned COORD_W   = 12;
  localparam int unsigned TIME_W    = 32;
  localparam int unsigned CFG_W     = 16;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned RFAIL_W   = 3;
  localparam int unsigned EMPTY_W   = 2;

  localparam int unsigned IN_TDATA_W  = 64;
  localparam int unsigned OUT_TDATA_W = 32;

  localparam int unsigned PANEL_WIDTH_DEF     = 320;
  localparam int unsigned PANEL_HEIGHT_DEF    = 480;
  localparam int unsigned SCREEN_WIDTH_DEF    = 480;
  localparam int unsigned SCREEN_HEIGHT_DEF   = 320;
  localparam int unsigned RELEASE_SAMPLES_DEF = 2;
  localparam int unsigned MAX_FAILURES_DEF    = 5;

  localparam logic [CFG_W-1:0] POLL_IVL_RST     = 16'd10;
  localparam logic [CFG_W-1:0] FAIL_BACKOFF_RST = 16'd50;
  localparam logic [CFG_W-1:0] RECOVERY_RST     = 16'd1000;
  localparam logic [CFG_W-1:0] IGNORE_RST       = 16'd0;

  typedef enum logic [1:0] {
    OP_POLL   = 2'd0,
    OP_CANCEL = 2'd1,
    OP_END    = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    PH_START = 2'd0,
    PH_MOVE  = 2'd1,
    PH_END   = 2'd2
  } phase_e;

  typedef enum logic [1:0] {
    OR_PORTRAIT       = 2'd0,
    OR_PORTRAIT_FLIP  = 2'd1,
    OR_LANDSCAPE      = 2'd2,
    OR_LANDSCAPE_FLIP = 2'd3
  } orient_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ORIENT       = 3'd0,
    REG_PANEL_ROT    = 3'd1,
    REG_POLL_IVL     = 3'd2,
    REG_FAIL_BACKOFF = 3'd3,
    REG_RECOVERY     = 3'd4,
    REG_IGNORE       = 3'd5
  } reg_e;

  typedef struct packed {
    orient_e          orientation;
    logic             panel_rotated;
    logic [CFG_W-1:0] poll_ivl;
    logic [CFG_W-1:0] fail_backoff;
    logic [CFG_W-1:0] recovery;
    logic [CFG_W-1:0] ignore_ms;
  } cfg_t;

  typedef struct packed {
    op_e                op;
    logic [TIME_W-1:0]  now;
    logic               probe_ok;
    logic               data_ready;
    logic               read_ok;
    logic               decode_ok;
    logic               pressed;
    logic [COORD_W-1:0] raw_x;
    logic [COORD_W-1:0] raw_y;
  } item_t;

  typedef struct packed {
    logic               valid;
    logic               touch_down;
    phase_e             phase;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
  } result_t;

endpackage

/* sv/tet_regs.sv */
// touch event tracker configuration registers
// depends on tet_pkg; flags a runtime clear when orientation changes

module tet_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [tet_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [tet_pkg::CFG_W-1:0]     cfg_wdata_i,
  output tet_pkg::cfg_t                 cfg_o,
  output logic                          clear_o
);

  tet_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d   = cfg_q;
    clear_o = 1'b0;
    if (cfg_we_i) begin
      case (tet_pkg::reg_e'(cfg_idx_i))
        tet_pkg::REG_ORIENT: begin
          if (cfg_wdata_i[1:0] != cfg_q.orientation) begin
            cfg_d.orientation = tet_pkg::orient_e'(cfg_wdata_i[1:0]);
            clear_o           = 1'b1;
          end
        end
        tet_pkg::REG_PANEL_ROT:    cfg_d.panel_rotated = cfg_wdata_i[0];
        tet_pkg::REG_POLL_IVL:     cfg_d.poll_ivl      = cfg_wdata_i;
        tet_pkg::REG_FAIL_BACKOFF: cfg_d.fail_backoff  = cfg_wdata_i;
        tet_pkg::REG_RECOVERY:     cfg_d.recovery      = cfg_wdata_i;
        tet_pkg::REG_IGNORE:       cfg_d.ignore_ms     = cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.orientation   <= tet_pkg::OR_PORTRAIT;
      cfg_q.panel_rotated <= 1'b0;
      cfg_q.poll_ivl      <= tet_pkg::POLL_IVL_RST;
      cfg_q.fail_backoff  <= tet_pkg::FAIL_BACKOFF_RST;
      cfg_q.recovery      <= tet_pkg::RECOVERY_RST;
      cfg_q.ignore_ms     <= tet_pkg::IGNORE_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* sv/tet_map.sv */
// touch event tracker coordinate mapping: panel clamp, 180 degree flip, rotation
// depends on tet_pkg; purely combinational

module tet_map #(
  parameter int unsigned PANEL_WIDTH   = tet_pkg::PANEL_WIDTH_DEF,
  parameter int unsigned PANEL_HEIGHT  = tet_pkg::PANEL_HEIGHT_DEF,
  parameter int unsigned SCREEN_WIDTH  = tet_pkg::SCREEN_WIDTH_DEF,
  parameter int unsigned SCREEN_HEIGHT = tet_pkg::SCREEN_HEIGHT_DEF
) (
  input  tet_pkg::cfg_t                 cfg_i,
  input  logic [tet_pkg::COORD_W-1:0]   raw_x_i,
  input  logic [tet_pkg::COORD_W-1:0]   raw_y_i,
  output logic [tet_pkg::COORD_W-1:0]   screen_x_o,
  output logic [tet_pkg::COORD_W-1:0]   screen_y_o
);

  localparam int unsigned CW = tet_pkg::COORD_W;
  localparam logic [CW-1:0] WMAX  = CW'(PANEL_WIDTH - 1);
  localparam logic [CW-1:0] HMAX  = CW'(PANEL_HEIGHT - 1);
  localparam logic [CW-1:0] SXMAX = CW'(SCREEN_WIDTH - 1);
  localparam logic [CW-1:0] SYMAX = CW'(SCREEN_HEIGHT - 1);

  logic [CW-1:0] cx, cy, px, py, inv_px, inv_py;

  always_comb begin
    cx     = (raw_x_i > WMAX) ? WMAX : raw_x_i;
    cy     = (raw_y_i > HMAX) ? HMAX : raw_y_i;
    px     = cfg_i.panel_rotated ? (WMAX - cx) : cx;
    py     = cfg_i.panel_rotated ? (HMAX - cy) : cy;
    inv_px = WMAX - px;
    inv_py = HMAX - py;
    case (cfg_i.orientation)
      tet_pkg::OR_PORTRAIT: begin
        screen_x_o = px;
        screen_y_o = py;
      end
      tet_pkg::OR_PORTRAIT_FLIP: begin
        screen_x_o = inv_px;
        screen_y_o = inv_py;
      end
      tet_pkg::OR_LANDSCAPE: begin
        screen_x_o = (inv_py > SXMAX) ? SXMAX : inv_py;
        screen_y_o = (px > SYMAX) ? SYMAX : px;
      end
      default: begin
        screen_x_o = (py > SXMAX) ? SXMAX : py;
        screen_y_o = (inv_px > SYMAX) ? SYMAX : inv_px;
      end
    endcase
  end

endmodule

/* sv/tet_core.sv */
// touch event tracker state and event decision for one poll, cancel or end
// depends on tet_pkg and tet_map; result is combinational, registered by the top

module tet_core #(
  parameter int unsigned PANEL_WIDTH     = tet_pkg::PANEL_WIDTH_DEF,
  parameter int unsigned PANEL_HEIGHT    = tet_pkg::PANEL_HEIGHT_DEF,
  parameter int unsigned SCREEN_WIDTH    = tet_pkg::SCREEN_WIDTH_DEF,
  parameter int unsigned SCREEN_HEIGHT   = tet_pkg::SCREEN_HEIGHT_DEF,
  parameter int unsigned RELEASE_SAMPLES = tet_pkg::RELEASE_SAMPLES_DEF,
  parameter int unsigned MAX_FAILURES    = tet_pkg::MAX_FAILURES_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  tet_pkg::cfg_t    cfg_i,
  input  logic             clear_i,
  input  logic             proc_i,
  input  tet_pkg::item_t   item_i,
  output tet_pkg::result_t result_o
);

  localparam int unsigned CW = tet_pkg::COORD_W;
  localparam int unsigned TW = tet_pkg::TIME_W;
  localparam int unsigned RW = tet_pkg::RFAIL_W;
  localparam int unsigned EW = tet_pkg::EMPTY_W;
  localparam int unsigned PADW = TW - tet_pkg::CFG_W;
  localparam logic [EW-1:0] REL_N  = EW'(RELEASE_SAMPLES);
  localparam logic [RW-1:0] MAXF_N = RW'(MAX_FAILURES);
  localparam logic [EW-1:0] EC_MAX = '1;
  localparam logic [RW-1:0] RF_MAX = '1;

  logic          init_q, init_d;
  logic [TW-1:0] last_poll_q, last_poll_d;
  logic [TW-1:0] backoff_q, backoff_d;
  logic [TW-1:0] ignore_q, ignore_d;
  logic [RW-1:0] rfail_q, rfail_d;
  logic [EW-1:0] empty_q, empty_d;
  logic          active_q, active_d;
  logic [CW-1:0] held_x_q, held_x_d;
  logic [CW-1:0] held_y_q, held_y_d;

  logic [CW-1:0] map_x, map_y;
  logic [TW-1:0] since_poll, tgt_fail, tgt_rec, tgt_ign;
  logic          before_backoff, before_ignore, poll_early;
  logic [EW-1:0] ec_inc;
  logic [RW-1:0] rf_inc;
  logic          rel_req;

  tet_map #(
    .PANEL_WIDTH  (PANEL_WIDTH),
    .PANEL_HEIGHT (PANEL_HEIGHT),
    .SCREEN_WIDTH (SCREEN_WIDTH),
    .SCREEN_HEIGHT(SCREEN_HEIGHT)
  ) u_map (
    .cfg_i     (cfg_i),
    .raw_x_i   (item_i.raw_x),
    .raw_y_i   (item_i.raw_y),
    .screen_x_o(map_x),
    .screen_y_o(map_y)
  );

  assign since_poll     = item_i.now - last_poll_q;
  assign poll_early     = since_poll < {{PADW{1'b0}}, cfg_i.poll_ivl};
  assign before_backoff = item_i.now < backoff_q;
  assign before_ignore  = item_i.now < ignore_q;
  assign tgt_fail       = item_i.now + {{PADW{1'b0}}, cfg_i.fail_backoff};
  assign tgt_rec        = item_i.now + {{PADW{1'b0}}, cfg_i.recovery};
  assign tgt_ign        = item_i.now + {{PADW{1'b0}}, cfg_i.ignore_ms};
  assign ec_inc         = (empty_q == EC_MAX) ? empty_q : empty_q + EW'(1);
  assign rf_inc         = (rfail_q == RF_MAX) ? rfail_q : rfail_q + RW'(1);

  always_comb begin
    init_d      = init_q;
    last_poll_d = last_poll_q;
    backoff_d   = backoff_q;
    ignore_d    = ignore_q;
    rfail_d     = rfail_q;
    empty_d     = empty_q;
    active_d    = active_q;
    held_x_d    = held_x_q;
    held_y_d    = held_y_q;
    rel_req     = 1'b0;
    result_o    = '{valid: 1'b0, touch_down: 1'b0, phase: tet_pkg::PH_START,
                    x: held_x_q, y: held_y_q};

    if (clear_i) begin
      last_poll_d = '0;
      backoff_d   = '0;
      ignore_d    = '0;
      rfail_d     = '0;
      empty_d     = '0;
      active_d    = 1'b0;
      held_x_d    = '0;
      held_y_d    = '0;
    end else if (proc_i) begin
      case (item_i.op)
        tet_pkg::OP_CANCEL, tet_pkg::OP_END: begin
          last_poll_d = '0;
          backoff_d   = '0;
          ignore_d    = '0;
          rfail_d     = '0;
          empty_d     = '0;
          active_d    = 1'b0;
          held_x_d    = '0;
          held_y_d    = '0;
          if (item_i.op == tet_pkg::OP_END) begin
            init_d = 1'b0;
          end
        end
        tet_pkg::OP_POLL: begin
          if (!init_q) begin
            // probe attempt once the backoff has run out
            if (!before_backoff) begin
              last_poll_d = '0;
              backoff_d   = '0;
              ignore_d    = '0;
              rfail_d     = '0;
              empty_d     = '0;
              active_d    = 1'b0;
              held_x_d    = '0;
              held_y_d    = '0;
              init_d      = item_i.probe_ok;
              if (item_i.probe_ok) begin
                if (cfg_i.ignore_ms != '0) begin
                  ignore_d = tgt_ign;
                end
              end else begin
                backoff_d = tgt_rec;
              end
            end
          end else if (!before_backoff && !poll_early) begin
            last_poll_d = item_i.now;
            if (!item_i.data_ready) begin
              rel_req = 1'b1;
            end else if (!item_i.read_ok) begin
              backoff_d = tgt_fail;
              rfail_d   = rf_inc;
              if (rf_inc >= MAXF_N) begin
                init_d    = 1'b0;
                active_d  = 1'b0;
                empty_d   = '0;
                backoff_d = tgt_rec;
              end
            end else begin
              rfail_d = '0;
              if (!item_i.decode_ok) begin
                backoff_d = tgt_fail;
              end else if (!item_i.pressed) begin
                rel_req = 1'b1;
              end else if (before_ignore) begin
                active_d = 1'b0;
                empty_d  = '0;
              end else begin
                backoff_d  = '0;
                empty_d    = '0;
                active_d   = 1'b1;
                held_x_d   = map_x;
                held_y_d   = map_y;
                result_o   = '{valid: 1'b1, touch_down: 1'b1,
                               phase: active_q ? tet_pkg::PH_MOVE : tet_pkg::PH_START,
                               x: map_x, y: map_y};
              end
            end
          end
        end
        default: ;
      endcase

      // empty sample while a touch is held
      if (rel_req && active_q) begin
        if (ec_inc < REL_N) begin
          empty_d = ec_inc;
        end else begin
          active_d = 1'b0;
          empty_d  = '0;
          result_o = '{valid: 1'b1, touch_down: 1'b0, phase: tet_pkg::PH_END,
                       x: held_x_q, y: held_y_q};
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_q      <= 1'b0;
      last_poll_q <= '0;
      backoff_q   <= '0;
      ignore_q    <= '0;
      rfail_q     <= '0;
      empty_q     <= '0;
      active_q    <= 1'b0;
      held_x_q    <= '0;
      held_y_q    <= '0;
    end else begin
      init_q      <= init_d;
      last_poll_q <= last_poll_d;
      backoff_q   <= backoff_d;
      ignore_q    <= ignore_d;
      rfail_q     <= rfail_d;
      empty_q     <= empty_d;
      active_q    <= active_d;
      held_x_q    <= held_x_d;
      held_y_q    <= held_y_d;
    end
  end

endmodule

/* sv/touch_event_tracker.sv */
// touch event tracker top level: input register, core, result register
// depends on tet_pkg, tet_regs, tet_core (which holds tet_map)
//
//   channel   direction  tdata / index            tuser
//   s_axis    in         poll item, 64 bits       operation
//   m_axis    out        touch event, 32 bits     phase
//   cfg       in         register index 0..5      -
//
// one item per cycle while the output is not stalled; the input register takes
// the item at its transfer, the result register takes the event once the output
// is free; reset clears all state but the payload registers; orientation change
// also clears runtime state; a stalled result holds the item behind it in the
// input register; tready drops only while both registers are full

module touch_event_tracker #(
  parameter int unsigned PANEL_WIDTH     = tet_pkg::PANEL_WIDTH_DEF,
  parameter int unsigned PANEL_HEIGHT    = tet_pkg::PANEL_HEIGHT_DEF,
  parameter int unsigned SCREEN_WIDTH    = tet_pkg::SCREEN_WIDTH_DEF,
  parameter int unsigned SCREEN_HEIGHT   = tet_pkg::SCREEN_HEIGHT_DEF,
  parameter int unsigned RELEASE_SAMPLES = tet_pkg::RELEASE_SAMPLES_DEF,
  parameter int unsigned MAX_FAILURES    = tet_pkg::MAX_FAILURES_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // now_ms, probe_ok, data_ready, read_ok, decode_ok, pressed, raw_x, raw_y
  input  logic [tet_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  // operation
  input  logic [1:0]                        s_axis_tuser,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // touch_down, screen_x, screen_y
  output logic [tet_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
  // phase
  output logic [1:0]                        m_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  input  logic                              cfg_we_i,
  input  logic [tet_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [tet_pkg::CFG_W-1:0]         cfg_wdata_i
);

  localparam int unsigned CW   = tet_pkg::COORD_W;
  localparam int unsigned OPAD = tet_pkg::OUT_TDATA_W - 1 - 2 * CW;

  tet_pkg::cfg_t    cfg;
  logic             cfg_clear;
  tet_pkg::item_t   item_d, item_q;
  logic             in_valid_q;
  tet_pkg::result_t res, out_q;
  logic             out_valid_q;
  logic             out_free, proc;

  assign out_free      = !out_valid_q || m_axis_tready;
  assign proc          = in_valid_q && out_free;
  assign s_axis_tready = !in_valid_q || out_free;

  assign item_d = '{op:         tet_pkg::op_e'(s_axis_tuser),
                    now:        s_axis_tdata[31:0],
                    probe_ok:   s_axis_tdata[32],
                    data_ready: s_axis_tdata[33],
                    read_ok:    s_axis_tdata[34],
                    decode_ok:  s_axis_tdata[35],
                    pressed:    s_axis_tdata[36],
                    raw_x:      s_axis_tdata[48:37],
                    raw_y:      s_axis_tdata[60:49]};

  tet_regs u_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .cfg_o      (cfg),
    .clear_o    (cfg_clear)
  );

  tet_core #(
    .PANEL_WIDTH    (PANEL_WIDTH),
    .PANEL_HEIGHT   (PANEL_HEIGHT),
    .SCREEN_WIDTH   (SCREEN_WIDTH),
    .SCREEN_HEIGHT  (SCREEN_HEIGHT),
    .RELEASE_SAMPLES(RELEASE_SAMPLES),
    .MAX_FAILURES   (MAX_FAILURES)
  ) u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg),
    .clear_i (cfg_clear),
    .proc_i  (proc),
    .item_i  (item_q),
    .result_o(res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (proc) begin
        out_valid_q <= res.valid;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      item_q <= item_d;
    end
    if (proc && res.valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{OPAD{1'b0}}, out_q.y, out_q.x, out_q.touch_down};
  assign m_axis_tuser  = out_q.phase;

endmodule

/* sv/tet_checker.sv */
// touch event tracker port checker and its bind to the top level
// depends on tet_pkg and touch_event_tracker

module tet_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_axis_tvalid,
  input logic                            s_axis_tready,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [tet_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input logic [1:0]                      m_axis_tuser
);

  // a stalled event holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled touch event changed");

  // touch_down set exactly for start and move
  a_down_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[0] == (m_axis_tuser != tet_pkg::PH_END)))
    else $error("touch_down disagrees with phase");

  // a new event follows an input transfer through the input and result registers
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 2))
    else $error("touch event without input transfer");

  // input stalls only behind a stalled event
  a_ready_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input stalled without output backpressure");

endmodule

bind touch_event_tracker tet_checker u_tet_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tuser (m_axis_tuser)
);
